// ----- rtl/mktm_pkg.sv -----
`timescale 1ns / 1ps

package mktm_pkg;

	localparam int DefMaxKeys = 128;

	localparam int KeyW    = 32;
	localparam int OffW    = 16;
	localparam int ModeW   = 32;
	localparam int IdxOutW = 7;
	localparam int CntOutW = 8;

	// s_axis_tdata: key_value, mask_value, byte_offset, offset_mode (112 bits)
	localparam int InDataW = 112;
	// s_axis_tuser: start_new, width_sel
	localparam int InUserW = 3;
	// m_axis_tdata: entry_index, entry_data, entry_bits, key_count, pad (80 bits)
	localparam int OutDataW = 80;
	// m_axis_tuser: status
	localparam int OutUserW = 3;

	typedef enum logic [1:0] {
		WSEL_RAW32  = 2'd0,
		WSEL_HOST32 = 2'd1,
		WSEL_16     = 2'd2,
		WSEL_8      = 2'd3
	} wsel_t;

	typedef enum logic [2:0] {
		ST_MERGED     = 3'd0,
		ST_APPENDED   = 3'd1,
		ST_CONFLICT   = 3'd2,
		ST_FULL       = 3'd3,
		ST_MISALIGNED = 3'd4,
		ST_TOO_WIDE   = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_RESOLVE
	} fsm_state_t;

	typedef struct packed {
		logic             start_new;
		wsel_t            width_sel;
		logic [KeyW-1:0]  key_value;
		logic [KeyW-1:0]  mask_value;
		logic [OffW-1:0]  byte_offset;
		logic [ModeW-1:0] offset_mode;
	} in_item_t;

	typedef struct packed {
		status_t             status;
		logic [IdxOutW-1:0]  entry_index;
		logic [KeyW-1:0]     entry_data;
		logic [KeyW-1:0]     entry_bits;
		logic [CntOutW-1:0]  key_count;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic scan;
		logic resolve;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_done;
	} dp_sts_t;

	function automatic logic [KeyW-1:0] swap32(input logic [KeyW-1:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

endpackage

// ----- rtl/mktm_ctrl.sv -----
`timescale 1ns / 1ps

module mktm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output mktm_pkg::dp_cmd_t cmd,
	input  mktm_pkg::dp_sts_t sts
);
	import mktm_pkg::*;

	fsm_state_t state_q, state_nxt;
	logic       out_valid_q;
	logic       accept;
	logic       resolve_go;

	assign accept     = in_valid && (state_q == S_IDLE);
	assign resolve_go = (state_q == S_RESOLVE) && (!out_valid_q || out_ready);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) state_nxt = S_SCAN;
			end
			S_SCAN: begin
				if (sts.scan_done) state_nxt = S_RESOLVE;
			end
			S_RESOLVE: begin
				if (resolve_go) state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = (state_q == S_IDLE);
		cmd.load    = accept;
		cmd.scan    = (state_q == S_SCAN);
		cmd.resolve = resolve_go;
		out_valid   = out_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (resolve_go)     out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

// ----- rtl/mktm_dp.sv -----
`timescale 1ns / 1ps

module mktm_dp #(
	parameter int MAX_KEYS = mktm_pkg::DefMaxKeys
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mktm_pkg::in_item_t  in_item,
	input  mktm_pkg::dp_cmd_t   cmd,
	output mktm_pkg::dp_sts_t   sts,
	output mktm_pkg::out_item_t out_item
);
	import mktm_pkg::*;

	localparam int IdxW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
	localparam int CntW = $clog2(MAX_KEYS + 1);

	typedef struct packed {
		logic [KeyW-1:0]  data;
		logic [KeyW-1:0]  bits;
		logic [OffW-1:0]  off;
		logic [ModeW-1:0] mode;
	} entry_t;

	entry_t mem [MAX_KEYS];

	// key preparation
	logic [KeyW-1:0] key_sh, mask_sh, key_nw, mask_nw;
	logic [OffW-1:0] off_al;
	logic            too_wide;

	always_comb begin
		key_sh   = in_item.key_value;
		mask_sh  = in_item.mask_value;
		off_al   = in_item.byte_offset;
		too_wide = 1'b0;
		case (in_item.width_sel)
			WSEL_16: begin
				too_wide = (in_item.key_value[31:16] != '0) ||
				           (in_item.mask_value[31:16] != '0);
				if (in_item.byte_offset[1:0] == 2'd0) begin
					key_sh  = {in_item.key_value[15:0], 16'h0000};
					mask_sh = {in_item.mask_value[15:0], 16'h0000};
				end
				off_al = {in_item.byte_offset[OffW-1:2], 2'b00};
			end
			WSEL_8: begin
				too_wide = (in_item.key_value[31:8] != '0) ||
				           (in_item.mask_value[31:8] != '0);
				case (in_item.byte_offset[1:0])
					2'd0: begin
						key_sh  = {in_item.key_value[7:0], 24'h000000};
						mask_sh = {in_item.mask_value[7:0], 24'h000000};
					end
					2'd1: begin
						key_sh  = {8'h00, in_item.key_value[7:0], 16'h0000};
						mask_sh = {8'h00, in_item.mask_value[7:0], 16'h0000};
					end
					2'd2: begin
						key_sh  = {16'h0000, in_item.key_value[7:0], 8'h00};
						mask_sh = {16'h0000, in_item.mask_value[7:0], 8'h00};
					end
					default: begin
						key_sh  = in_item.key_value;
						mask_sh = in_item.mask_value;
					end
				endcase
				off_al = {in_item.byte_offset[OffW-1:2], 2'b00};
			end
			default: ;
		endcase
		if (in_item.width_sel != WSEL_RAW32) begin
			key_nw  = swap32(key_sh);
			mask_nw = swap32(mask_sh);
		end else begin
			key_nw  = key_sh;
			mask_nw = mask_sh;
		end
	end

	// working registers for the current word
	logic [KeyW-1:0]  key_q, mask_q;
	logic [OffW-1:0]  off_q;
	logic [ModeW-1:0] mode_q;
	logic             too_wide_q;
	logic [CntW-1:0]  cnt_q, cnt_nxt;
	logic [CntW-1:0]  scan_idx_q;

	// scan pipeline
	entry_t          rd_s1;
	logic            rd_vld_s1;
	logic [IdxW-1:0] cmp_idx_s1;
	logic            issue, hit_now, conflict_now;

	logic            hit_q, conflict_q;
	logic [IdxW-1:0] hit_idx_q;
	logic [KeyW-1:0] hit_data_q, hit_bits_q;

	assign hit_now = rd_vld_s1 && (rd_s1.off == off_q) && (rd_s1.mode == mode_q);
	assign conflict_now = ((key_q ^ rd_s1.data) & (mask_q & rd_s1.bits)) != '0;
	assign issue = cmd.scan && !too_wide_q && !hit_q && !hit_now &&
	               (scan_idx_q < cnt_q);

	assign sts.scan_done = too_wide_q || hit_q || hit_now || (!issue && !rd_vld_s1);

	// resolve: decide, write back, fill output register
	logic            we;
	logic [IdxW-1:0] waddr;
	entry_t          wdata;
	out_item_t       res;

	always_comb begin
		we      = 1'b0;
		waddr   = hit_idx_q;
		wdata   = '{data: hit_data_q, bits: hit_bits_q, off: off_q, mode: mode_q};
		cnt_nxt = cnt_q;
		res     = '0;
		if (too_wide_q) begin
			res.status = ST_TOO_WIDE;
		end else if (hit_q) begin
			res.status      = conflict_q ? ST_CONFLICT : ST_MERGED;
			res.entry_index = IdxOutW'(hit_idx_q);
			res.entry_data  = hit_data_q;
			res.entry_bits  = hit_bits_q;
			we              = !conflict_q;
		end else if (cnt_q >= CntW'(MAX_KEYS)) begin
			res.status = ST_FULL;
		end else if (off_q[1:0] != 2'b00) begin
			res.status = ST_MISALIGNED;
		end else begin
			res.status      = ST_APPENDED;
			res.entry_index = IdxOutW'(cnt_q);
			res.entry_data  = key_q;
			res.entry_bits  = mask_q;
			we              = 1'b1;
			waddr           = cnt_q[IdxW-1:0];
			wdata           = '{data: key_q, bits: mask_q, off: off_q, mode: mode_q};
			cnt_nxt         = cnt_q + 1'b1;
		end
		res.key_count = CntOutW'(cnt_nxt);
	end

	// table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.resolve && we) mem[waddr] <= wdata;
		rd_s1 <= mem[scan_idx_q[IdxW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q  <= key_nw & mask_nw;
			mask_q <= mask_nw;
			off_q  <= off_al;
			mode_q <= in_item.offset_mode;
		end
		if (issue) cmp_idx_s1 <= scan_idx_q[IdxW-1:0];
		if (cmd.scan && hit_now && !hit_q) begin
			hit_idx_q  <= cmp_idx_s1;
			conflict_q <= conflict_now;
			hit_data_q <= conflict_now ? rd_s1.data : (rd_s1.data | key_q);
			hit_bits_q <= conflict_now ? rd_s1.bits : (rd_s1.bits | mask_q);
		end
		if (cmd.resolve) out_item <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			scan_idx_q <= '0;
			rd_vld_s1  <= 1'b0;
			hit_q      <= 1'b0;
			too_wide_q <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (cmd.load) begin
				scan_idx_q <= '0;
				hit_q      <= 1'b0;
				too_wide_q <= too_wide;
				if (in_item.start_new) cnt_q <= '0;
			end else begin
				if (issue) scan_idx_q <= scan_idx_q + 1'b1;
				if (cmd.scan && hit_now) hit_q <= 1'b1;
				if (cmd.resolve) cnt_q <= cnt_nxt;
			end
		end
	end

endmodule

// ----- rtl/match_key_table_merge.sv -----
`timescale 1ns / 1ps

// Match key table builder.
// Input channel s_axis: one word per requested key. tuser carries start_new
// (clear the table first) and width_sel; tdata carries value, mask, byte
// offset and offset-mode word. Output channel m_axis: one result word per
// input word, with the status in tuser and entry index, stored value, stored
// mask and key count in tdata.
// Scanning: the stored entries are scanned one per cycle through the single
// read port of the table memory, and a hit at an entry ends the scan there.
// Narrow keys whose value or mask is too wide skip the scan.
// One word is in work at a time; s_axis_tready rises in the cycle after the
// previous result has been placed in the output register.
// Reset empties the table (the key count goes to zero, no clearing pass is
// needed) and drops any pending result.
// When the receiver stalls, the result holds in the output register; the
// block still accepts and scans the next word, then holds before write-back
// until the output register frees up.
module match_key_table_merge #(
	parameter int MAX_KEYS = mktm_pkg::DefMaxKeys
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// [31:0] key_value, [63:32] mask_value, [79:64] byte_offset,
	// [111:80] offset_mode
	input  logic [mktm_pkg::InDataW-1:0]  s_axis_tdata,
	// [0] start_new, [2:1] width_sel
	input  logic [mktm_pkg::InUserW-1:0]  s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// [6:0] entry_index, [38:7] entry_data, [70:39] entry_bits,
	// [78:71] key_count, [79] zero
	output logic [mktm_pkg::OutDataW-1:0] m_axis_tdata,
	// [2:0] status
	output logic [mktm_pkg::OutUserW-1:0] m_axis_tuser
);
	import mktm_pkg::*;

	in_item_t  in_item;
	out_item_t out_item;
	dp_cmd_t   cmd;
	dp_sts_t   sts;

	// unpack the incoming word
	assign in_item.start_new   = s_axis_tuser[0];
	assign in_item.width_sel   = wsel_t'(s_axis_tuser[2:1]);
	assign in_item.key_value   = s_axis_tdata[31:0];
	assign in_item.mask_value  = s_axis_tdata[63:32];
	assign in_item.byte_offset = s_axis_tdata[79:64];
	assign in_item.offset_mode = s_axis_tdata[111:80];

	mktm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	mktm_dp #(
		.MAX_KEYS (MAX_KEYS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (in_item),
		.cmd      (cmd),
		.sts      (sts),
		.out_item (out_item)
	);

	// pack the result word
	assign m_axis_tuser = out_item.status;
	assign m_axis_tdata = {1'b0, out_item.key_count, out_item.entry_bits,
	                       out_item.entry_data, out_item.entry_index};

endmodule

// ----- tb/match_key_table_merge_tb.sv -----
`timescale 1ns / 1ps

module match_key_table_merge_tb;
	import mktm_pkg::*;

	localparam int TableDepth = DefMaxKeys;
	localparam int ItemGoal   = 900;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	// [31:0] key_value, [63:32] mask_value, [79:64] byte_offset, [111:80] offset_mode
	logic [InDataW-1:0]  s_axis_tdata = '0;
	// [0] start_new, [2:1] width_sel
	logic [InUserW-1:0]  s_axis_tuser = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	// [6:0] entry_index, [38:7] entry_data, [70:39] entry_bits, [78:71] key_count
	logic [OutDataW-1:0] m_axis_tdata;
	// [2:0] status
	logic [OutUserW-1:0] m_axis_tuser;

	match_key_table_merge dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #6 clk = ~clk;

	// Shadow copy of the key table.
	logic [31:0] tbl_data [TableDepth];
	logic [31:0] tbl_bits [TableDepth];
	logic [15:0] tbl_off  [TableDepth];
	logic [31:0] tbl_mode [TableDepth];
	int          tbl_count = 0;

	in_item_t    key_requests [$];
	out_item_t   table_updates [$];
	int          n_keys = 0;
	int          keys_taken = 0;
	int          mismatches = 0;
	logic        word_taken = 1'b0;

	function automatic logic [31:0] net_order(logic [31:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

	// Apply one key request to the shadow table and return the expected word.
	function automatic out_item_t merge_key(in_item_t req);
		logic [31:0] k;
		logic [31:0] m;
		logic [15:0] off;
		int          sh;
		int          i;
		out_item_t   r;
		r   = '0;
		k   = req.key_value;
		m   = req.mask_value;
		off = req.byte_offset;
		if (req.start_new)
			tbl_count = 0;
		r.key_count = 8'(tbl_count);
		// narrow keys must fit their lane, otherwise no entry is merged or added
		if ((req.width_sel == WSEL_16 && (k > 32'hFFFF || m > 32'hFFFF)) ||
		    (req.width_sel == WSEL_8 && (k > 32'hFF || m > 32'hFF))) begin
			r.status = ST_TOO_WIDE;
			return r;
		end
		if (req.width_sel == WSEL_16) begin
			if (off[1:0] == 2'd0) begin
				k = k << 16;
				m = m << 16;
			end
			off[1:0] = 2'd0;
		end else if (req.width_sel == WSEL_8) begin
			sh = (3 - off[1:0]) * 8;
			k = k << sh;
			m = m << sh;
			off[1:0] = 2'd0;
		end
		if (req.width_sel != WSEL_RAW32) begin
			k = net_order(k);
			m = net_order(m);
		end
		k &= m;
		for (i = 0; i < tbl_count; i++) begin
			if (tbl_off[i] == off && tbl_mode[i] == req.offset_mode) begin
				r.entry_index = 7'(i);
				if (((k ^ tbl_data[i]) & m & tbl_bits[i]) == 32'd0) begin
					tbl_data[i] |= k;
					tbl_bits[i] |= m;
					r.status = ST_MERGED;
				end else begin
					r.status = ST_CONFLICT;
				end
				r.entry_data = tbl_data[i];
				r.entry_bits = tbl_bits[i];
				return r;
			end
		end
		if (tbl_count >= TableDepth) begin
			r.status = ST_FULL;
		end else if (off[1:0] != 2'd0) begin
			r.status = ST_MISALIGNED;
		end else begin
			tbl_data[tbl_count] = k;
			tbl_bits[tbl_count] = m;
			tbl_off[tbl_count]  = off;
			tbl_mode[tbl_count] = req.offset_mode;
			r.status      = ST_APPENDED;
			r.entry_index = 7'(tbl_count);
			r.entry_data  = k;
			r.entry_bits  = m;
			tbl_count++;
			r.key_count = 8'(tbl_count);
		end
		return r;
	endfunction

	task automatic add_key(logic start, wsel_t sel, logic [31:0] k, logic [31:0] m,
	                       logic [15:0] off, logic [31:0] mode);
		in_item_t it;
		it.start_new   = start;
		it.width_sel   = sel;
		it.key_value   = k;
		it.mask_value  = m;
		it.byte_offset = off;
		it.offset_mode = mode;
		key_requests.push_back(it);
	endtask

	function automatic logic [31:0] pick_mask();
		case ($urandom_range(4))
			0: return 32'hFFFF_FFFF;
			1: return $urandom;
			2: return $urandom & $urandom;
			3: return 32'hFF << (8 * $urandom_range(3));
			default: return 32'd0;
		endcase
	endfunction

	// One selector: clear the table, then keys spread over a few offset/mode
	// slots, with values drawn from a per-slot base so that merges happen.
	task automatic add_selector();
		logic [15:0] offs [4];
		logic [31:0] modes [4];
		logic [31:0] bases [4];
		logic [31:0] k;
		logic [31:0] m;
		logic [15:0] off;
		int          n_slots;
		int          len;
		int          s;
		int          i;
		wsel_t       sel;
		n_slots = $urandom_range(1, 4);
		for (i = 0; i < 4; i++) begin
			if ($urandom_range(3) == 0)
				offs[i] = 16'($urandom) & 16'hFFFC;
			else
				offs[i] = 16'($urandom_range(15) * 4);
			case ($urandom_range(3))
				0, 1: modes[i] = 32'd0;
				2: modes[i] = 32'hFFFF_FFFF;
				default: modes[i] = $urandom;
			endcase
			bases[i] = $urandom;
		end
		len = $urandom_range(2, 30);
		for (i = 0; i < len; i++) begin
			s = $urandom_range(n_slots - 1);
			if (i > 0 && $urandom_range(9) == 0) begin
				// noise word, any field at all
				add_key($urandom_range(15) == 0, wsel_t'($urandom_range(3)), $urandom,
				        $urandom, 16'($urandom), $urandom);
			end else begin
				sel = wsel_t'($urandom_range(3));
				m   = pick_mask();
				off = offs[s];
				case (sel)
					WSEL_16: begin
						k = {16'h0, bases[s][15:0]};
						m &= 32'hFFFF;
						off[1:0] = 2'($urandom_range(3));
						if ($urandom_range(11) == 0) begin
							if ($urandom_range(1))
								k[$urandom_range(16, 31)] = 1'b1;
							else
								m[$urandom_range(16, 31)] = 1'b1;
						end
					end
					WSEL_8: begin
						k = {24'h0, bases[s][7:0]};
						m &= 32'hFF;
						off[1:0] = 2'($urandom_range(3));
						if ($urandom_range(11) == 0) begin
							if ($urandom_range(1))
								k[$urandom_range(8, 31)] = 1'b1;
							else
								m[$urandom_range(8, 31)] = 1'b1;
						end
					end
					default: begin
						k = ($urandom_range(7) == 0) ? $urandom : bases[s];
						if ($urandom_range(15) == 0)
							off[1:0] = 2'($urandom_range(1, 3));
					end
				endcase
				add_key(i == 0, sel, k, m, off, modes[s]);
			end
		end
	endtask

	// Fill the table to the last entry, then send hits, misses and a too-wide key while full.
	task automatic add_fill_run();
		logic [31:0] mode;
		int          i;
		mode = $urandom;
		for (i = 0; i < TableDepth; i++)
			add_key(i == 0, WSEL_RAW32, $urandom, pick_mask(), 16'(i * 4), mode);
		add_key(1'b0, WSEL_RAW32, $urandom, 32'd0, 16'd20, mode);
		add_key(1'b0, WSEL_RAW32, $urandom, $urandom, 16'd20, mode);
		add_key(1'b0, WSEL_RAW32, $urandom, $urandom, 16'd1024, mode);
		add_key(1'b0, WSEL_8, 32'h5A, 32'hFF, 16'd1025, mode);
		add_key(1'b0, WSEL_RAW32, $urandom, $urandom, 16'd3, ~mode);
		add_key(1'b0, WSEL_16, 32'h1_0000, 32'hFFFF, 16'd0, mode);
	endtask

	// Sender: bursts of words with random gaps; hold a word until it is taken.
	in_item_t cur;
	int       burst_left = 0;
	int       gap_left = 0;

	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (s_axis_tvalid && !word_taken) begin
			// hold
		end else if (gap_left > 0) begin
			gap_left--;
			s_axis_tvalid <= 1'b0;
		end else if (key_requests.size() > 0) begin
			cur = key_requests.pop_front();
			s_axis_tdata  <= {cur.offset_mode, cur.byte_offset, cur.mask_value, cur.key_value};
			s_axis_tuser  <= {cur.width_sel, cur.start_new};
			s_axis_tvalid <= 1'b1;
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				burst_left = $urandom_range(10);
				case ($urandom_range(2))
					0: gap_left = 0;
					1: gap_left = $urandom_range(3);
					default: gap_left = $urandom_range(150);
				endcase
			end
		end else begin
			s_axis_tvalid <= 1'b0;
		end
	end

	// Receiver: stall style changes every so often, from never to long holds.
	int stall_left = 0;
	int stall_style = 0;
	int style_timer = 0;

	always @(negedge clk) begin
		if (style_timer == 0) begin
			stall_style = $urandom_range(3);
			style_timer = $urandom_range(500, 3000);
		end else begin
			style_timer--;
		end
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			case (stall_style)
				1: if ($urandom_range(3) == 0) stall_left = $urandom_range(1, 4);
				2: if ($urandom_range(15) == 0) stall_left = $urandom_range(20, 100);
				3: if ($urandom_range(1) == 0) stall_left = $urandom_range(1, 40);
				default: ;
			endcase
		end
	end

	// Monitor: predict on each accepted key word, check each result word.
	always @(posedge clk) begin
		in_item_t  req;
		out_item_t got;
		out_item_t want;
		word_taken <= s_axis_tvalid && s_axis_tready && arst_n;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			req.start_new   = s_axis_tuser[0];
			req.width_sel   = wsel_t'(s_axis_tuser[2:1]);
			req.key_value   = s_axis_tdata[31:0];
			req.mask_value  = s_axis_tdata[63:32];
			req.byte_offset = s_axis_tdata[79:64];
			req.offset_mode = s_axis_tdata[111:80];
			table_updates.push_back(merge_key(req));
			keys_taken++;
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.status      = status_t'(m_axis_tuser);
			got.entry_index = m_axis_tdata[6:0];
			got.entry_data  = m_axis_tdata[38:7];
			got.entry_bits  = m_axis_tdata[70:39];
			got.key_count   = m_axis_tdata[78:71];
			if (table_updates.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result word st=%0d idx=%0d", $time,
					         got.status, got.entry_index);
			end else begin
				want = table_updates.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"%0t: want st=%0d idx=%0d data=%h bits=%h cnt=%0d, ",
						          "got st=%0d idx=%0d data=%h bits=%h cnt=%0d"},
						         $time, want.status, want.entry_index, want.entry_data,
						         want.entry_bits, want.key_count, got.status,
						         got.entry_index, got.entry_data, got.entry_bits,
						         got.key_count);
				end
			end
		end
	end

	initial begin
		// directed: lane shifts, byte order, merge, conflict, too-wide and misaligned rejects
		add_key(1'b1, WSEL_RAW32, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0, 32'd0);
		add_key(1'b0, WSEL_RAW32, 32'h0, 32'h0, 16'd0, 32'd0);
		add_key(1'b0, WSEL_RAW32, 32'h0, 32'h1, 16'd0, 32'd0);
		add_key(1'b0, WSEL_HOST32, 32'h1234_5678, 32'hFFFF_0000, 16'd8, 32'hFFFF_FFFF);
		add_key(1'b0, WSEL_HOST32, 32'h0000_5555, 32'h0000_FFFF, 16'd8, 32'hFFFF_FFFF);
		add_key(1'b0, WSEL_16, 32'hABCD, 32'hFFFF, 16'd4, 32'd0);
		add_key(1'b0, WSEL_16, 32'h1234, 32'hFFFF, 16'd6, 32'd0);
		add_key(1'b0, WSEL_16, 32'h1_0000, 32'h1, 16'd4, 32'd0);
		add_key(1'b0, WSEL_16, 32'h1, 32'h1_0000, 16'd5, 32'd0);
		add_key(1'b0, WSEL_8, 32'h11, 32'hFF, 16'd12, 32'd0);
		add_key(1'b0, WSEL_8, 32'h22, 32'hFF, 16'd13, 32'd0);
		add_key(1'b0, WSEL_8, 32'h33, 32'hFF, 16'd14, 32'd0);
		add_key(1'b0, WSEL_8, 32'h44, 32'hFF, 16'd15, 32'd0);
		add_key(1'b0, WSEL_8, 32'h100, 32'h1, 16'd16, 32'd0);
		add_key(1'b0, WSEL_8, 32'h1, 32'hFFFF_FFFF, 16'd17, 32'd0);
		add_key(1'b0, WSEL_RAW32, 32'hCAFE_F00D, 32'hFFFF_FFFF, 16'd3, 32'd0);
		add_key(1'b0, WSEL_RAW32, 32'hCAFE_F00D, 32'hFFFF_FFFF, 16'h7FFF, 32'd0);
		add_key(1'b0, WSEL_RAW32, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h8000, 32'h7FFF_FFFF);
		add_key(1'b0, WSEL_HOST32, 32'h0, 32'hFFFF_FFFF, 16'hFFFC, 32'h8000_0000);
		add_key(1'b0, WSEL_16, 32'hFFFF, 32'hFFFF, 16'hFFFE, 32'h8000_0000);
		add_key(1'b1, WSEL_8, 32'h1FF, 32'h0, 16'd0, 32'd0);
		add_key(1'b0, WSEL_RAW32, 32'hDEAD_BEEF, 32'hFFFF_FFFF, 16'd0, 32'd0);
		add_key(1'b1, WSEL_RAW32, 32'hDEAD_BEEF, 32'h0, 16'd0, 32'd0);
		// random selectors, with one run that fills the table part way through
		while (key_requests.size() < ItemGoal / 3)
			add_selector();
		add_fill_run();
		while (key_requests.size() < ItemGoal)
			add_selector();
		n_keys = key_requests.size();

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (keys_taken < n_keys || table_updates.size() != 0)
			@(negedge clk);
		// let a stray word show up if the block has one
		repeat (150) @(negedge clk);
		if (mismatches == 0)
			$display("PASS match_key_table_merge");
		else
			$display("FAIL match_key_table_merge");
		$finish;
	end

	initial begin
		#25_000_000;
		$display("FAIL match_key_table_merge");
		$finish;
	end

endmodule
